[rtl/core/lbct_pkg.sv]
// Shared types and codes for the labelled byte counter table.
package lbct_pkg;

    localparam int OP_BITS     = 2;
    localparam int IN_LBL_BITS = 8;
    localparam int AMT_BITS    = 32;
    localparam int VALUE_BITS  = 54;
    localparam int STATUS_BITS = 2;
    localparam int KIND_BITS   = 3;

    // request operations
    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SUB   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_TOTAL = 2'd3;

    // result status
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNDER = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_OVER  = 2'd3;

    // classified command kinds, front to back
    localparam logic [KIND_BITS-1:0] K_ADD   = 3'd0;
    localparam logic [KIND_BITS-1:0] K_SUB   = 3'd1;
    localparam logic [KIND_BITS-1:0] K_READ  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_TOTAL = 3'd3;
    localparam logic [KIND_BITS-1:0] K_FULL  = 3'd4;
    localparam logic [KIND_BITS-1:0] K_ZERO  = 3'd5;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 is_new;
        logic [AMT_BITS-1:0]  amount;
    } cmd_t;

endpackage

[rtl/core/lbct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbct_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/lbct_front.sv]
// Front end: key lookup in the tag array, entry allocation and command classification.
module lbct_front #(
    parameter int ENTRIES    = 64,
    parameter int LABEL_BITS = 8,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [lbct_pkg::OP_BITS-1:0]      operation,
    input  logic [lbct_pkg::IN_LBL_BITS-1:0]  label,
    input  logic [lbct_pkg::IN_LBL_BITS-1:0]  sub_label,
    input  logic [lbct_pkg::AMT_BITS-1:0]     amount,
    output lbct_pkg::cmd_t                    cmd,
    output logic [IW-1:0]                     cmd_idx
);

    localparam int UW = $clog2(ENTRIES + 1);
    localparam int KW = 2 * LABEL_BITS;
    localparam int XW = LABEL_BITS + lbct_pkg::IN_LBL_BITS;

    logic [KW-1:0]  key_reg [ENTRIES];
    logic [UW-1:0]  used_reg, used_next;

    logic [XW-1:0]         lab_x, sub_x;
    logic [KW-1:0]         key;
    logic [ENTRIES-1:0]    match;
    logic                  hit;
    logic [IW-1:0]         hit_idx;
    logic                  full;
    logic                  alloc;

    // only the low LABEL_BITS of each label take part in the key
    assign lab_x = {{LABEL_BITS{1'b0}}, label};
    assign sub_x = {{LABEL_BITS{1'b0}}, sub_label};
    assign key   = {lab_x[LABEL_BITS-1:0], sub_x[LABEL_BITS-1:0]};

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (UW'(i) < used_reg) && (key_reg[i] == key);
            if (match[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    assign hit  = |match;
    assign full = (used_reg == UW'(ENTRIES));

    always_comb
    begin
        cmd.amount = amount;
        cmd.is_new = 1'b0;
        cmd.kind   = lbct_pkg::K_ZERO;
        cmd_idx    = hit_idx;
        alloc      = 1'b0;
        if (operation == lbct_pkg::OP_TOTAL)
        begin
            cmd.kind = lbct_pkg::K_TOTAL;
        end
        else if (operation == lbct_pkg::OP_SUB && amount == '0)
        begin
            cmd.kind = lbct_pkg::K_ZERO;
        end
        else if (!hit && full)
        begin
            cmd.kind = lbct_pkg::K_FULL;
        end
        else
        begin
            case (operation)
                lbct_pkg::OP_ADD: cmd.kind = lbct_pkg::K_ADD;
                lbct_pkg::OP_SUB: cmd.kind = lbct_pkg::K_SUB;
                default:          cmd.kind = lbct_pkg::K_READ;
            endcase
            if (!hit)
            begin
                alloc      = 1'b1;
                cmd.is_new = 1'b1;
                cmd_idx    = used_reg[IW-1:0];
            end
        end
    end

    assign used_next = (accept && alloc) ? used_reg + UW'(1) : used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && alloc)
        begin
            key_reg[used_reg[IW-1:0]] <= key;
        end
    end

endmodule

[rtl/core/lbct_queue.sv]
// Two-slot command queue between front and back.
module lbct_queue #(
    parameter int IW = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lbct_pkg::cmd_t push_cmd,
    input  logic [IW-1:0]  push_idx,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output lbct_pkg::cmd_t pop_cmd,
    output logic [IW-1:0]  pop_idx
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    lbct_pkg::cmd_t cmd_reg [DEPTH];
    logic [IW-1:0]  idx_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = cmd_reg[rd_ptr_reg];
    assign pop_idx = idx_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg] <= push_cmd;
            idx_reg[wr_ptr_reg] <= push_idx;
        end
    end

endmodule

[rtl/core/lbct_back.sv]
// Back end: counter read-modify-write, running total and result register.
module lbct_back #(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 48,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  lbct_pkg::cmd_t                       q_cmd,
    input  logic [IW-1:0]                        q_idx,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lbct_pkg::VALUE_BITS-1:0]      out_value,
    output logic [lbct_pkg::STATUS_BITS-1:0]     out_status
);

    localparam int VB = lbct_pkg::VALUE_BITS;
    localparam int W  = ((COUNT_BITS > lbct_pkg::AMT_BITS) ? COUNT_BITS
                                                          : lbct_pkg::AMT_BITS) + 1;
    localparam int XW = COUNT_BITS + VB;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 state_reg, state_next;
    lbct_pkg::cmd_t       cur_cmd_reg;
    logic [IW-1:0]        cur_idx_reg;
    logic [VB-1:0]        total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VB-1:0]        out_value_reg, out_value_next;
    logic [lbct_pkg::STATUS_BITS-1:0] out_status_reg, out_status_next;

    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] old_cnt, new_cnt;
    logic [W-1:0]          old_w, amt_w, sum_w, diff_w;
    logic [XW-1:0]         old_x, new_x;
    logic                  fire;
    logic                  wr_en;

    lbct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_idx_reg),
        .wr_data (new_cnt),
        .rd_en   (q_pop),
        .rd_addr (q_idx),
        .rd_data (rd_data)
    );

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign fire  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // a freshly made entry has no stored value yet: it counts as zero
    assign old_cnt = cur_cmd_reg.is_new ? '0 : rd_data;
    assign old_w   = {{(W-COUNT_BITS){1'b0}}, old_cnt};
    assign amt_w   = {{(W-lbct_pkg::AMT_BITS){1'b0}}, cur_cmd_reg.amount};
    assign sum_w   = old_w + amt_w;
    assign diff_w  = old_w - amt_w;
    assign old_x   = {{VB{1'b0}}, old_cnt};
    assign new_x   = {{VB{1'b0}}, new_cnt};

    always_comb
    begin
        new_cnt         = old_cnt;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        total_next      = total_reg;
        state_next      = state_reg;
        wr_en           = 1'b0;
        if (q_pop)
        begin
            state_next = ST_EXEC;
        end
        if (fire)
        begin
            state_next      = ST_IDLE;
            out_valid_next  = 1'b1;
            out_value_next  = '0;
            out_status_next = lbct_pkg::ST_OK;
            case (cur_cmd_reg.kind)
                lbct_pkg::K_ADD:
                begin
                    new_cnt        = sum_w[COUNT_BITS-1:0];
                    wr_en          = 1'b1;
                    out_value_next = old_x[VB-1:0];
                    if (|sum_w[W-1:COUNT_BITS])
                    begin
                        out_status_next = lbct_pkg::ST_OVER;
                    end
                end
                lbct_pkg::K_SUB:
                begin
                    new_cnt        = diff_w[COUNT_BITS-1:0];
                    wr_en          = 1'b1;
                    out_value_next = old_x[VB-1:0];
                    if (diff_w[W-1])
                    begin
                        out_status_next = lbct_pkg::ST_UNDER;
                    end
                end
                lbct_pkg::K_READ:
                begin
                    wr_en          = 1'b1;
                    out_value_next = old_x[VB-1:0];
                end
                lbct_pkg::K_TOTAL:
                begin
                    out_value_next = total_reg;
                end
                lbct_pkg::K_FULL:
                begin
                    out_status_next = lbct_pkg::ST_FULL;
                end
                default:
                begin
                    out_value_next = '0;
                end
            endcase
            // running total tracks the sum of all counters modulo 2^VB;
            // only a counter write can move it
            if (wr_en)
            begin
                total_next = total_reg + new_x[VB-1:0] - old_x[VB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        if (q_pop)
        begin
            cur_cmd_reg <= q_cmd;
            cur_idx_reg <= q_idx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

[rtl/core/labelled_byte_counter_table_top.sv]
// Top level of the labelled byte counter table: front, command queue and back.
// An accepted beat is classified by the front end and queued; the back end pops it, reads the
// counter RAM and registers the result for m_axis. The back end takes a new request only after
// the last one has done its read-modify-write of the counter RAM (the read, then the write).
// Reset clears the entry count, the queue, the running total and the output valid flag;
// key and counter stores are not cleared, the entry count marks which entries are live.
module labelled_byte_counter_table_top #(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 48,
    parameter int LABEL_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bit 7:0 label, 15:8 sub_label, 47:16 amount
    input  logic [47:0] s_axis_tdata,
    // bit 1:0 operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bit 53:0 count_value, 55:54 zero fill
    output logic [55:0] m_axis_tdata,
    // bit 1:0 status
    output logic [1:0]  m_axis_tuser
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                  in_beat;
    logic                  q_full;
    lbct_pkg::cmd_t        front_cmd;
    logic [IW-1:0]         front_idx;

    logic                  q_valid;
    logic                  q_pop;
    lbct_pkg::cmd_t        q_cmd;
    logic [IW-1:0]         q_idx;

    logic [lbct_pkg::VALUE_BITS-1:0] out_value;

    // a beat is taken whenever the queue has room; the lookup and any
    // allocation are done in the same cycle so later beats see the new key
    assign s_axis_tready = !q_full;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    lbct_front #(
        .ENTRIES    (ENTRIES),
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_beat),
        .operation (s_axis_tuser),
        .label     (s_axis_tdata[7:0]),
        .sub_label (s_axis_tdata[15:8]),
        .amount    (s_axis_tdata[47:16]),
        .cmd       (front_cmd),
        .cmd_idx   (front_idx)
    );

    lbct_queue #(
        .IW (IW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_beat),
        .push_cmd (front_cmd),
        .push_idx (front_idx),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_cmd),
        .pop_idx  (q_idx)
    );

    // back end holds its result in an output register, so the queue keeps
    // filling while a result waits on m_axis
    lbct_back #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_idx      (q_idx),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (out_value),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, out_value};

endmodule
